// ===== rtl/lfpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types, register codes and constants of the line-follower PD drive.
// ----------------------------------------------------------------------------
package lfpd_pkg;

	// configuration port
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		REG_PROP_GAIN       = 3'd0,
		REG_DERIV_GAIN      = 3'd1,
		REG_LEFT_BASE       = 3'd2,
		REG_RIGHT_BASE      = 3'd3,
		REG_LEFT_SLOW_MAX   = 3'd4,
		REG_RIGHT_SLOW_MAX  = 3'd5,
		REG_LEFT_START_MAX  = 3'd6,
		REG_RIGHT_START_MAX = 3'd7
	} reg_idx_t;

	// register reset values
	localparam logic signed [15:0] PROP_GAIN_RST       = 16'sd256;
	localparam logic signed [15:0] DERIV_GAIN_RST      = 16'sd0;
	localparam logic [7:0]         LEFT_BASE_RST       = 8'd255;
	localparam logic [7:0]         RIGHT_BASE_RST      = 8'd80;
	localparam logic [7:0]         LEFT_SLOW_MAX_RST   = 8'd0;
	localparam logic [7:0]         RIGHT_SLOW_MAX_RST  = 8'd255;
	localparam logic [7:0]         LEFT_START_MAX_RST  = 8'd0;
	localparam logic [7:0]         RIGHT_START_MAX_RST = 8'd80;

	// sensor thresholds and position range
	localparam logic [9:0]         REFL_HI    = 10'd900;
	localparam logic [9:0]         REFL_LO    = 10'd100;
	localparam logic [12:0]        POS_MAX    = 13'd7000;
	localparam logic signed [13:0] POS_CENTER = 14'sd3500;

	// datapath widths
	localparam int ERR_W  = 13;
	localparam int DIFF_W = 14;
	localparam int CORR_W = 23;
	localparam int CMD_W  = 24;

	// drive mapping
	localparam logic [7:0]               DUTY_MAX    = 8'd255;
	localparam logic signed [CMD_W-1:0]  PULSE_CMD   = -24'sd1001;
	localparam logic signed [CMD_W-1:0]  BRAKE_LIMIT = -24'sd1000;
	localparam logic signed [CMD_W:0]    MAG_BASE    = -25'sd7;
	localparam int                       BRAKE_SPAN  = 4993;
	localparam int                       BRAKE_MAX_DEF = 255;
	// magnitude times brake ceiling at or above this gives a full duty
	localparam logic [20:0]              SAT_MAG     = 21'(BRAKE_SPAN * 256);
	// reciprocal of the span, exact for products below 2^21
	localparam int                       RECIP_SHIFT = 33;
	localparam logic [20:0]              RECIP       =
		21'(((64'd1 << RECIP_SHIFT) / BRAKE_SPAN) + 64'd1);

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_PULSE = 2'd1,
		MODE_TRACK = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [15:0] prop_gain;
		logic signed [15:0] deriv_gain;
		logic [7:0]         left_base;
		logic [7:0]         right_base;
		logic [7:0]         left_slow_max;
		logic [7:0]         right_slow_max;
		logic [7:0]         left_start_max;
		logic [7:0]         right_start_max;
	} cfg_t;

	// ceiling load on a start-ceiling write
	typedef struct packed {
		logic       load_left;
		logic       load_right;
		logic [7:0] value;
	} ceil_ld_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [ERR_W-1:0]  err;
		logic signed [DIFF_W-1:0] diff;
		logic [7:0]               lceil;
		logic [7:0]               rceil;
	} ctl_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [CORR_W-1:0] corr;
		logic [7:0]               lceil;
		logic [7:0]               rceil;
	} drv_t;

endpackage

// ===== rtl/lfpd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_cfg_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module lfpd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lfpd_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [lfpd_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [lfpd_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output lfpd_pkg::cfg_t                      cfg,
	output lfpd_pkg::ceil_ld_t                  ld
);

	logic               wr;
	lfpd_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = lfpd_pkg::reg_idx_t'(paddr[4:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.prop_gain       <= lfpd_pkg::PROP_GAIN_RST;
			cfg.deriv_gain      <= lfpd_pkg::DERIV_GAIN_RST;
			cfg.left_base       <= lfpd_pkg::LEFT_BASE_RST;
			cfg.right_base      <= lfpd_pkg::RIGHT_BASE_RST;
			cfg.left_slow_max   <= lfpd_pkg::LEFT_SLOW_MAX_RST;
			cfg.right_slow_max  <= lfpd_pkg::RIGHT_SLOW_MAX_RST;
			cfg.left_start_max  <= lfpd_pkg::LEFT_START_MAX_RST;
			cfg.right_start_max <= lfpd_pkg::RIGHT_START_MAX_RST;
		end else if (wr) begin
			case (idx)
				lfpd_pkg::REG_PROP_GAIN:       cfg.prop_gain       <= pwdata[15:0];
				lfpd_pkg::REG_DERIV_GAIN:      cfg.deriv_gain      <= pwdata[15:0];
				lfpd_pkg::REG_LEFT_BASE:       cfg.left_base       <= pwdata[7:0];
				lfpd_pkg::REG_RIGHT_BASE:      cfg.right_base      <= pwdata[7:0];
				lfpd_pkg::REG_LEFT_SLOW_MAX:   cfg.left_slow_max   <= pwdata[7:0];
				lfpd_pkg::REG_RIGHT_SLOW_MAX:  cfg.right_slow_max  <= pwdata[7:0];
				lfpd_pkg::REG_LEFT_START_MAX:  cfg.left_start_max  <= pwdata[7:0];
				lfpd_pkg::REG_RIGHT_START_MAX: cfg.right_start_max <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// start-ceiling writes also load the live ceilings
	assign ld.load_left  = wr && (idx == lfpd_pkg::REG_LEFT_START_MAX);
	assign ld.load_right = wr && (idx == lfpd_pkg::REG_RIGHT_START_MAX);
	assign ld.value      = pwdata[7:0];

	// read mux
	always_comb begin
		case (idx)
			lfpd_pkg::REG_PROP_GAIN:       prdata = {16'd0, cfg.prop_gain};
			lfpd_pkg::REG_DERIV_GAIN:      prdata = {16'd0, cfg.deriv_gain};
			lfpd_pkg::REG_LEFT_BASE:       prdata = {24'd0, cfg.left_base};
			lfpd_pkg::REG_RIGHT_BASE:      prdata = {24'd0, cfg.right_base};
			lfpd_pkg::REG_LEFT_SLOW_MAX:   prdata = {24'd0, cfg.left_slow_max};
			lfpd_pkg::REG_RIGHT_SLOW_MAX:  prdata = {24'd0, cfg.right_slow_max};
			lfpd_pkg::REG_LEFT_START_MAX:  prdata = {24'd0, cfg.left_start_max};
			lfpd_pkg::REG_RIGHT_START_MAX: prdata = {24'd0, cfg.right_start_max};
			default:                       prdata = '0;
		endcase
	end

endmodule

// ===== rtl/lfpd_ctrl_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_ctrl_state
// Run toggle, bar detection, speed ceilings and error tracking. Holds the
// loop state and updates it as each tick leaves the input stage.
// ----------------------------------------------------------------------------
module lfpd_ctrl_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [12:0]         line_pos,
	input  logic [7:0][9:0]     refl,
	input  logic                button_down,
	input  logic [7:0]          left_slow_max,
	input  logic [7:0]          right_slow_max,
	input  lfpd_pkg::ceil_ld_t  ld,
	output lfpd_pkg::ctl_t      ctl_s2
);

	logic                                 run_enable_q;
	logic                                 moving_q;
	logic signed [lfpd_pkg::ERR_W-1:0]    prev_error_q;
	logic [7:0]                           left_ceiling_q;
	logic [7:0]                           right_ceiling_q;

	logic [7:0]                           hi;
	logic [7:0]                           lo;
	logic                                 all_hi;
	logic                                 fast_bar;
	logic                                 slow_bar;
	logic                                 run_nx;
	logic                                 moving_bar;
	logic [7:0]                           lceil_nx;
	logic [7:0]                           rceil_nx;
	logic [12:0]                          pos_c;
	logic signed [13:0]                   err_w;
	logic signed [lfpd_pkg::ERR_W-1:0]    err;
	logic signed [lfpd_pkg::DIFF_W-1:0]   diff;
	lfpd_pkg::mode_t                      mode;

	// threshold compares per sensor
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hi[i] = refl[i] >= lfpd_pkg::REFL_HI;
			lo[i] = refl[i] <= lfpd_pkg::REFL_LO;
		end
	end

	// bar patterns
	assign all_hi   = &hi;
	assign fast_bar = (&hi[3:0]) & (&lo[7:5]);
	assign slow_bar = (&lo[2:0]) & (&hi[7:4]);

	assign run_nx     = run_enable_q ^ button_down;
	assign moving_bar = moving_q & ~all_hi;

	// ceilings after this tick's bars, slow bar wins
	always_comb begin
		lceil_nx = left_ceiling_q;
		rceil_nx = right_ceiling_q;
		if (fast_bar) begin
			lceil_nx = lfpd_pkg::DUTY_MAX;
			rceil_nx = lfpd_pkg::DUTY_MAX;
		end
		if (slow_bar) begin
			lceil_nx = left_slow_max;
			rceil_nx = right_slow_max;
		end
	end

	// centred error and its change
	assign pos_c = (line_pos > lfpd_pkg::POS_MAX) ? lfpd_pkg::POS_MAX : line_pos;
	assign err_w = $signed({1'b0, pos_c}) - lfpd_pkg::POS_CENTER;
	assign err   = err_w[lfpd_pkg::ERR_W-1:0];
	assign diff  = {err[lfpd_pkg::ERR_W-1], err} -
		{prev_error_q[lfpd_pkg::ERR_W-1], prev_error_q};

	// tick mode
	always_comb begin
		if (!run_nx) begin
			mode = lfpd_pkg::MODE_OFF;
		end else if (!moving_bar) begin
			mode = lfpd_pkg::MODE_PULSE;
		end else begin
			mode = lfpd_pkg::MODE_TRACK;
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_enable_q    <= 1'b0;
			moving_q        <= 1'b0;
			prev_error_q    <= '0;
			left_ceiling_q  <= lfpd_pkg::LEFT_START_MAX_RST;
			right_ceiling_q <= lfpd_pkg::RIGHT_START_MAX_RST;
		end else begin
			if (en) begin
				run_enable_q    <= run_nx;
				moving_q        <= run_nx | moving_bar;
				left_ceiling_q  <= lceil_nx;
				right_ceiling_q <= rceil_nx;
				if (mode == lfpd_pkg::MODE_TRACK) begin
					prev_error_q <= err;
				end
			end
			if (ld.load_left) begin
				left_ceiling_q <= ld.value;
			end
			if (ld.load_right) begin
				right_ceiling_q <= ld.value;
			end
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2.mode  <= mode;
			ctl_s2.err   <= err;
			ctl_s2.diff  <= diff;
			ctl_s2.lceil <= lceil_nx;
			ctl_s2.rceil <= rceil_nx;
		end
	end

endmodule

// ===== rtl/lfpd_pd_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_pd_calc
// PD correction: two Q8.8 products summed and floored to whole speed steps.
// ----------------------------------------------------------------------------
module lfpd_pd_calc (
	input  logic                clk,
	input  logic                en,
	input  lfpd_pkg::ctl_t      ctl_s2,
	input  logic signed [15:0]  prop_gain,
	input  logic signed [15:0]  deriv_gain,
	output lfpd_pkg::drv_t      drv_s3
);

	logic signed [lfpd_pkg::ERR_W-1:0]  err;
	logic signed [lfpd_pkg::DIFF_W-1:0] diff;
	logic signed [28:0]                 p_term;
	logic signed [29:0]                 d_term;
	logic signed [30:0]                 sum;

	assign err  = ctl_s2.err;
	assign diff = ctl_s2.diff;

	// products, then sum; dropping 8 bits floors toward minus infinity
	assign p_term = err * prop_gain;
	assign d_term = diff * deriv_gain;
	assign sum    = p_term + d_term;

	always_ff @(posedge clk) begin
		if (en) begin
			drv_s3.mode  <= ctl_s2.mode;
			drv_s3.corr  <= sum[30:8];
			drv_s3.lceil <= ctl_s2.lceil;
			drv_s3.rceil <= ctl_s2.rceil;
		end
	end

endmodule

// ===== rtl/lfpd_wheel_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_wheel_drive
// One wheel: command, ceiling clamp, forward duty or reverse brake duty.
// Two stages: clamp and scale, then divide by the brake span.
// ----------------------------------------------------------------------------
module lfpd_wheel_drive #(
	parameter int BRAKE_MAX = lfpd_pkg::BRAKE_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               en_s4,
	input  logic                               en_s5,
	input  lfpd_pkg::mode_t                    mode,
	input  logic signed [lfpd_pkg::CMD_W-1:0]  adj,
	input  logic [7:0]                         base,
	input  logic [7:0]                         ceiling,
	output logic [7:0]                         duty_s5,
	output logic                               brake_s5
);

	localparam logic [7:0] BRAKE_W = 8'(BRAKE_MAX);

	logic signed [lfpd_pkg::CMD_W-1:0] cmd_raw;
	logic signed [lfpd_pkg::CMD_W-1:0] cmd_sel;
	logic signed [lfpd_pkg::CMD_W-1:0] ceil_s;
	logic signed [lfpd_pkg::CMD_W-1:0] cmd_c;
	logic                              is_brake;
	logic [7:0]                        pos_duty;
	logic signed [lfpd_pkg::CMD_W:0]   mag;
	logic [20:0]                       mag_c;
	logic [28:0]                       scaled;
	logic                              sat;

	logic                              off_s4;
	logic                              brake_s4;
	logic                              sat_s4;
	logic [7:0]                        pos_s4;
	logic [20:0]                       x_s4;

	logic [41:0]                       qprod;
	logic [7:0]                        q;
	logic [7:0]                        duty_nx;

	// command and clamp
	assign cmd_raw = $signed({16'd0, base}) + adj;
	assign cmd_sel = (mode == lfpd_pkg::MODE_PULSE) ? lfpd_pkg::PULSE_CMD : cmd_raw;
	assign ceil_s  = $signed({16'd0, ceiling});
	assign cmd_c   = (cmd_sel > ceil_s) ? ceil_s : cmd_sel;

	assign is_brake = cmd_c < lfpd_pkg::BRAKE_LIMIT;

	// forward duty, saturated to 0..255
	always_comb begin
		if (cmd_c[lfpd_pkg::CMD_W-1]) begin
			pos_duty = 8'd0;
		end else if (cmd_c > $signed({16'd0, lfpd_pkg::DUTY_MAX})) begin
			pos_duty = lfpd_pkg::DUTY_MAX;
		end else begin
			pos_duty = cmd_c[7:0];
		end
	end

	// brake magnitude, capped where the duty is full anyway
	assign mag    = lfpd_pkg::MAG_BASE - {cmd_c[lfpd_pkg::CMD_W-1], cmd_c};
	assign mag_c  = (mag[23:0] >= {3'd0, lfpd_pkg::SAT_MAG}) ? lfpd_pkg::SAT_MAG
		: mag[20:0];
	assign scaled = 29'(mag_c) * 29'(BRAKE_W);
	assign sat    = scaled >= {8'd0, lfpd_pkg::SAT_MAG};

	always_ff @(posedge clk) begin
		if (en_s4) begin
			off_s4   <= (mode == lfpd_pkg::MODE_OFF);
			brake_s4 <= is_brake;
			sat_s4   <= sat;
			pos_s4   <= pos_duty;
			x_s4     <= scaled[20:0];
		end
	end

	// divide by the span through its reciprocal
	assign qprod = 42'(x_s4) * 42'(lfpd_pkg::RECIP);
	assign q     = qprod[lfpd_pkg::RECIP_SHIFT+7:lfpd_pkg::RECIP_SHIFT];

	always_comb begin
		if (off_s4) begin
			duty_nx = 8'd0;
		end else if (brake_s4) begin
			duty_nx = sat_s4 ? lfpd_pkg::DUTY_MAX : q;
		end else begin
			duty_nx = pos_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			duty_s5  <= duty_nx;
			brake_s5 <= ~off_s4 & brake_s4;
		end
	end

endmodule

// ===== rtl/line_follow_pd_motor_drive_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pd_motor_drive_top
// PD line-follower motor drive: one control tick in, one pair of wheel
// commands out.
// ----------------------------------------------------------------------------
// The block takes one control tick per clock while in_stall is low and passes
// it through the input register, state and bar update, PD multiply, clamp and
// brake scaling, and brake divide into the result register. Each stage
// advances on its own whenever the next one is empty or moving, so a stalled
// result holds only the stages behind it. Loop state (run enable, moving,
// previous error, speed ceilings) is updated as a tick leaves the input
// register, so the next tick sees it. The user writes configuration over
// the APB-style port only while no tick is in flight; the block does not
// enforce this. Writing a start ceiling also loads that live ceiling.
// ----------------------------------------------------------------------------
module line_follow_pd_motor_drive_top #(
	parameter int BRAKE_MAX = lfpd_pkg::BRAKE_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// tick input
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [12:0]                      line_pos,
	input  logic [9:0]                       refl_0,
	input  logic [9:0]                       refl_1,
	input  logic [9:0]                       refl_2,
	input  logic [9:0]                       refl_3,
	input  logic [9:0]                       refl_4,
	input  logic [9:0]                       refl_5,
	input  logic [9:0]                       refl_6,
	input  logic [9:0]                       refl_7,
	input  logic                             button_down,
	// result output
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       left_duty,
	output logic [7:0]                       right_duty,
	output logic                             left_brake,
	output logic                             right_brake,
	output logic                             halted,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lfpd_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [lfpd_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [lfpd_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready
);

	lfpd_pkg::cfg_t     cfg;
	lfpd_pkg::ceil_ld_t ld;
	lfpd_pkg::ctl_t     ctl_s2;
	lfpd_pkg::drv_t     drv_s3;

	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic               en_s1, en_s2, en_s3, en_s4, en_s5;
	logic [12:0]        line_pos_s1;
	logic [7:0][9:0]    refl_s1;
	logic               button_s1;
	logic               pulse_s4;
	logic               halted_s5;

	logic signed [lfpd_pkg::CMD_W-1:0] left_adj;
	logic signed [lfpd_pkg::CMD_W-1:0] right_adj;

	// stage advance chain
	assign en_s5    = valid_s4 & (~valid_s5 | ~out_stall);
	assign en_s4    = valid_s3 & (~valid_s4 | en_s5);
	assign en_s3    = valid_s2 & (~valid_s3 | en_s4);
	assign en_s2    = valid_s1 & (~valid_s2 | en_s3);
	assign in_stall = valid_s1 & ~en_s2;
	assign en_s1    = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= en_s1 | (valid_s1 & ~en_s2);
			valid_s2 <= en_s2 | (valid_s2 & ~en_s3);
			valid_s3 <= en_s3 | (valid_s3 & ~en_s4);
			valid_s4 <= en_s4 | (valid_s4 & ~en_s5);
			valid_s5 <= en_s5 | (valid_s5 & out_stall);
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en_s1) begin
			line_pos_s1 <= line_pos;
			refl_s1     <= {refl_7, refl_6, refl_5, refl_4,
				refl_3, refl_2, refl_1, refl_0};
			button_s1   <= button_down;
		end
	end

	lfpd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.ld      (ld)
	);

	lfpd_ctrl_state u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en_s2),
		.line_pos       (line_pos_s1),
		.refl           (refl_s1),
		.button_down    (button_s1),
		.left_slow_max  (cfg.left_slow_max),
		.right_slow_max (cfg.right_slow_max),
		.ld             (ld),
		.ctl_s2         (ctl_s2)
	);

	lfpd_pd_calc u_pd (
		.clk        (clk),
		.en         (en_s3),
		.ctl_s2     (ctl_s2),
		.prop_gain  (cfg.prop_gain),
		.deriv_gain (cfg.deriv_gain),
		.drv_s3     (drv_s3)
	);

	// correction added on the left, subtracted on the right
	assign left_adj  = {drv_s3.corr[lfpd_pkg::CORR_W-1], drv_s3.corr};
	assign right_adj = -left_adj;

	lfpd_wheel_drive #(
		.BRAKE_MAX (BRAKE_MAX)
	) u_left (
		.clk      (clk),
		.en_s4    (en_s4),
		.en_s5    (en_s5),
		.mode     (drv_s3.mode),
		.adj      (left_adj),
		.base     (cfg.left_base),
		.ceiling  (drv_s3.lceil),
		.duty_s5  (left_duty),
		.brake_s5 (left_brake)
	);

	lfpd_wheel_drive #(
		.BRAKE_MAX (BRAKE_MAX)
	) u_right (
		.clk      (clk),
		.en_s4    (en_s4),
		.en_s5    (en_s5),
		.mode     (drv_s3.mode),
		.adj      (right_adj),
		.base     (cfg.right_base),
		.ceiling  (drv_s3.rceil),
		.duty_s5  (right_duty),
		.brake_s5 (right_brake)
	);

	// stop pulse flag follows the wheel stages
	always_ff @(posedge clk) begin
		if (en_s4) begin
			pulse_s4 <= (drv_s3.mode == lfpd_pkg::MODE_PULSE);
		end
		if (en_s5) begin
			halted_s5 <= pulse_s4;
		end
	end

	assign halted    = halted_s5;
	assign out_valid = valid_s5;

endmodule
